### hw/rtl/dlpe_pkg.sv
// Shared types, codes and tables for the display list palette engine
`timescale 1ns / 1ps

package dlpe_pkg;

    localparam int PALETTE_ENTRIES   = 32;
    localparam int PEN_W             = $clog2(PALETTE_ENTRIES);
    localparam int LIST_ADDRESS_BITS = 20;
    localparam int CFG_INDEX_W       = 4;

    // input item modes
    localparam logic [1:0] MODE_FRAME = 2'd0;
    localparam logic [1:0] MODE_WORD  = 2'd1;
    localparam logic [1:0] MODE_LINE  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_HEAD = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SWAP = 4'd1;

    // word phase within an entry
    localparam logic [2:0] PH_HDR  = 3'd0;
    localparam logic [2:0] PH_CUR  = 3'd1;
    localparam logic [2:0] PH_PREV = 3'd2;
    localparam logic [2:0] PH_NEXT = 3'd3;
    localparam logic [2:0] PH_CMD  = 3'd4;

    // command word codes
    localparam logic [7:0]  CMD_BACKGROUND = 8'hE0;
    localparam logic [2:0]  CMD_CONTROL    = 3'b110;
    localparam logic [31:0] CMD_RAMP       = 32'hFFFF_FFFF;

    // colour write component select
    localparam logic [1:0] SEL_ALL   = 2'b00;
    localparam logic [1:0] SEL_BLUE  = 2'b01;
    localparam logic [1:0] SEL_GREEN = 2'b10;
    localparam logic [1:0] SEL_RED   = 2'b11;

    localparam logic [LIST_ADDRESS_BITS-1:0] HEAD_RESET = 20'hB0000;

    // one colour lookup write or ramp restore
    typedef struct packed {
        logic             ramp;
        logic             we_r;
        logic             we_g;
        logic             we_b;
        logic [PEN_W-1:0] pen;
        logic [7:0]       r;
        logic [7:0]       g;
        logic [7:0]       b;
    } pal_wr_t;

    // default ramp value of entry j: j*8 + j/4
    function automatic logic [7:0] ramp_value(input logic [PEN_W-1:0] j);
        ramp_value = {j, j[4:2]};
    endfunction

    // line pitch from the header pitch code
    function automatic logic [10:0] pitch_of(input logic [2:0] code);
        logic [10:0] p;
        unique case (code)
            3'd1:    p = 11'd384;
            3'd2:    p = 11'd512;
            3'd3:    p = 11'd640;
            3'd4:    p = 11'd1024;
            default: p = 11'd320;
        endcase
        pitch_of = p;
    endfunction

endpackage

### hw/rtl/display_list_palette_engine.sv
// Display list engine top level: list walker, line stepping and result register
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_mode, s_list_word, s_pen_index
//  m_        out        m_valid / m_ready    fetch, bitmap, colour and palette fields
//  cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle while s_ready is high: each transfer is worked in the cycle
// it is taken and its result sits in the output register the next cycle.
// s_ready is high whenever the output register is empty or being drained.
// cfg_ready is always high; writes take effect at the next edge.
// Synchronous active-low reset; the colour tables reload the default ramp in
// the reset cycle, so no clearing pass follows.
`timescale 1ns / 1ps

module display_list_palette_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_mode,
    input  logic [31:0]                   s_list_word,
    input  logic [dlpe_pkg::PEN_W-1:0]    s_pen_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_fetch_request,
    output logic [dlpe_pkg::LIST_ADDRESS_BITS-1:0] m_fetch_address,
    output logic                          m_entry_done,
    output logic [31:0]                   m_current_bitmap,
    output logic [31:0]                   m_previous_bitmap,
    output logic [23:0]                   m_background_colour,
    output logic [31:0]                   m_display_control,
    output logic [31:0]                   m_entry_header,
    output logic [7:0]                    m_pen_red,
    output logic [7:0]                    m_pen_green,
    output logic [7:0]                    m_pen_blue,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dlpe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import dlpe_pkg::*;

    localparam int AW = LIST_ADDRESS_BITS;

    // configuration registers
    logic [AW-1:0] head_reg;
    logic          swap_reg;

    // walker state
    logic [2:0]    word_phase_reg, word_phase_next;
    logic [5:0]    commands_left_reg, commands_left_next;
    logic [31:0]   header_reg, header_next;
    logic [AW-1:0] list_ptr_reg, list_ptr_next;
    logic [AW-1:0] next_ptr_reg, next_ptr_next;
    logic [31:0]   cur_bm_reg, cur_bm_next;
    logic [31:0]   prev_bm_reg, prev_bm_next;
    logic [10:0]   pitch_reg, pitch_next;
    logic [8:0]    lines_left_reg, lines_left_next;
    logic          stopped_reg, stopped_next;
    logic          chain_reg, chain_next;
    logic          ignore_reg, ignore_next;
    logic [23:0]   background_reg, background_next;
    logic [31:0]   control_reg, control_next;

    // output register
    logic          m_valid_reg;
    logic          req_next, done_next;
    logic          req_reg, done_reg;
    logic [7:0]    pen_r_reg, pen_g_reg, pen_b_reg;
    logic [7:0]    rd_r, rd_g, rd_b;

    logic          in_fire;
    logic          finish;
    logic [AW-1:0] finish_ptr;
    logic [31:0]   w;
    logic [31:0]   cur_adv;
    logic [5:0]    cmd_dec;
    logic [8:0]    lines_dec;
    pal_wr_t       pal_wr;

    assign s_ready   = !m_valid_reg || m_ready;
    assign in_fire   = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign w         = s_list_word;
    assign cmd_dec   = commands_left_reg - 6'd1;
    assign lines_dec = lines_left_reg - 9'd1;

    // step one bitmap address: by two within a line, else back to the even word of the next line
    function automatic logic [31:0] advance(input logic [31:0] a, input logic [10:0] p);
        if (a[1])
            advance = a + {19'd0, p, 2'b00} - 32'd2;
        else
            advance = a + 32'd2;
    endfunction

    assign cur_adv = advance(cur_bm_reg, pitch_reg);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= HEAD_RESET;
            swap_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_HEAD) head_reg <= cfg_data[AW-1:0];
            if (cfg_index == CFG_SWAP) swap_reg <= cfg_data[0];
        end
    end

    // next state for one transfer
    always_comb begin
        word_phase_next    = word_phase_reg;
        commands_left_next = commands_left_reg;
        header_next        = header_reg;
        list_ptr_next      = list_ptr_reg;
        next_ptr_next      = next_ptr_reg;
        cur_bm_next        = cur_bm_reg;
        prev_bm_next       = prev_bm_reg;
        pitch_next         = pitch_reg;
        lines_left_next    = lines_left_reg;
        stopped_next       = stopped_reg;
        chain_next         = chain_reg;
        ignore_next        = ignore_reg;
        background_next    = background_reg;
        control_next       = control_reg;
        req_next           = 1'b0;
        done_next          = 1'b0;
        finish             = 1'b0;
        finish_ptr         = next_ptr_reg;
        pal_wr             = '0;
        pal_wr.pen         = w[24 +: PEN_W];
        pal_wr.r           = w[23:16];
        pal_wr.g           = w[15:8];
        pal_wr.b           = w[7:0];

        unique case (s_mode)
            MODE_FRAME: begin
                list_ptr_next      = head_reg;
                word_phase_next    = PH_HDR;
                commands_left_next = 6'd0;
                ignore_next        = 1'b0;
                lines_left_next    = 9'd0;
                stopped_next       = 1'b0;
                chain_next         = 1'b1;
                req_next           = 1'b1;
            end
            MODE_WORD: begin
                if (!stopped_reg) begin
                    unique case (word_phase_reg)
                        PH_HDR: begin
                            if (w == 32'd0) begin
                                lines_left_next = 9'd511;
                                chain_next      = 1'b0;
                                done_next       = 1'b1;
                            end else begin
                                header_next        = w;
                                commands_left_next = w[14:9];
                                ignore_next        = 1'b0;
                                word_phase_next    = PH_CUR;
                            end
                        end
                        PH_CUR: begin
                            if (swap_reg ? header_reg[15] : header_reg[16]) begin
                                if (swap_reg) prev_bm_next = w;
                                else          cur_bm_next  = w;
                            end
                            word_phase_next = PH_PREV;
                        end
                        PH_PREV: begin
                            if (swap_reg ? header_reg[16] : header_reg[15]) begin
                                if (swap_reg) cur_bm_next  = w;
                                else          prev_bm_next = w;
                            end
                            word_phase_next = PH_NEXT;
                        end
                        PH_NEXT: begin
                            if (header_reg[18])
                                next_ptr_next = list_ptr_reg + w[AW-1:0] + AW'(16);
                            else
                                next_ptr_next = w[AW-1:0];
                            finish_ptr = next_ptr_next;
                            if (commands_left_reg == 6'd0) finish = 1'b1;
                            else word_phase_next = PH_CMD;
                        end
                        default: begin
                            // command word
                            if (!w[31]) begin
                                unique case (w[30:29])
                                    SEL_ALL: begin
                                        pal_wr.we_r = in_fire;
                                        pal_wr.we_g = in_fire;
                                        pal_wr.we_b = in_fire;
                                    end
                                    SEL_RED:   pal_wr.we_r = in_fire;
                                    SEL_GREEN: pal_wr.we_g = in_fire;
                                    SEL_BLUE:  pal_wr.we_b = in_fire;
                                endcase
                            end else if (w[31:24] == CMD_BACKGROUND) begin
                                if (!ignore_reg)
                                    background_next = {w[7:0], w[15:8], w[23:16]};
                            end else if (w[31:29] == CMD_CONTROL) begin
                                if (!ignore_reg) begin
                                    control_next = w;
                                    ignore_next  = w[1];
                                end
                            end else if (w == CMD_RAMP) begin
                                if (!ignore_reg) pal_wr.ramp = in_fire;
                            end
                            commands_left_next = cmd_dec;
                            if (cmd_dec == 6'd0) finish = 1'b1;
                        end
                    endcase

                    // close out a non-zero entry
                    if (finish) begin
                        done_next          = 1'b1;
                        word_phase_next    = PH_HDR;
                        commands_left_next = 6'd0;
                        pitch_next         = pitch_of(header_reg[25:23]);
                        list_ptr_next      = finish_ptr;
                        lines_left_next    = header_reg[8:0];
                        if (header_reg[8:0] != 9'd0) begin
                            chain_next = 1'b0;
                        end else if (chain_reg) begin
                            chain_next = 1'b0;
                            req_next   = 1'b1;
                        end else begin
                            stopped_next = 1'b1;
                        end
                    end
                end
            end
            MODE_LINE: begin
                cur_bm_next  = cur_adv;
                prev_bm_next = header_reg[17] ? advance(prev_bm_reg, pitch_reg) : cur_adv;
                if (!stopped_reg && lines_left_reg != 9'd0) begin
                    lines_left_next = lines_dec;
                    if (lines_dec == 9'd0) req_next = 1'b1;
                end
                control_next = {control_reg[31:1], 1'b0};
            end
            default: begin
            end
        endcase
    end

    dlpe_palette u_palette (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (pal_wr),
        .rd_pen  (s_pen_index),
        .rd_r    (rd_r),
        .rd_g    (rd_g),
        .rd_b    (rd_b)
    );

    // walker state update on an input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_phase_reg    <= PH_HDR;
            commands_left_reg <= 6'd0;
            header_reg        <= 32'd0;
            list_ptr_reg      <= '0;
            next_ptr_reg      <= '0;
            cur_bm_reg        <= 32'd0;
            prev_bm_reg       <= 32'd0;
            pitch_reg         <= 11'd320;
            lines_left_reg    <= 9'd0;
            stopped_reg       <= 1'b1;
            chain_reg         <= 1'b0;
            ignore_reg        <= 1'b0;
            background_reg    <= 24'd0;
            control_reg       <= 32'd0;
        end else if (in_fire) begin
            word_phase_reg    <= word_phase_next;
            commands_left_reg <= commands_left_next;
            header_reg        <= header_next;
            list_ptr_reg      <= list_ptr_next;
            next_ptr_reg      <= next_ptr_next;
            cur_bm_reg        <= cur_bm_next;
            prev_bm_reg       <= prev_bm_next;
            pitch_reg         <= pitch_next;
            lines_left_reg    <= lines_left_next;
            stopped_reg       <= stopped_next;
            chain_reg         <= chain_next;
            ignore_reg        <= ignore_next;
            background_reg    <= background_next;
            control_reg       <= control_next;
        end
    end

    // result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            req_reg   <= req_next;
            done_reg  <= done_next;
            pen_r_reg <= rd_r;
            pen_g_reg <= rd_g;
            pen_b_reg <= rd_b;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_fetch_request     = req_reg;
    assign m_entry_done        = done_reg;
    assign m_fetch_address     = list_ptr_reg;
    assign m_current_bitmap    = cur_bm_reg;
    assign m_previous_bitmap   = prev_bm_reg;
    assign m_background_colour = background_reg;
    assign m_display_control   = control_reg;
    assign m_entry_header      = header_reg;
    assign m_pen_red           = pen_r_reg;
    assign m_pen_green         = pen_g_reg;
    assign m_pen_blue          = pen_b_reg;

    // checks
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled with empty result register");

    a_frame_requests: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_mode == MODE_FRAME) |=>
            (m_valid && m_fetch_request && m_fetch_address == $past(head_reg)))
        else $error("frame start did not request the head entry");

    a_done_at_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_entry_done) |-> (word_phase_reg == PH_HDR))
        else $error("entry done while walker is mid entry");

    a_no_commands_at_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (word_phase_reg == PH_HDR) |-> (commands_left_reg == 6'd0))
        else $error("command count left over at header phase");

endmodule

### hw/rtl/dlpe_palette.sv
// Colour lookup table: three 32-entry component tables with write bypass on read
`timescale 1ns / 1ps

module dlpe_palette (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dlpe_pkg::pal_wr_t     wr,
    input  logic [dlpe_pkg::PEN_W-1:0] rd_pen,
    output logic [7:0]            rd_r,
    output logic [7:0]            rd_g,
    output logic [7:0]            rd_b
);
    import dlpe_pkg::*;

    logic [7:0] red_reg   [PALETTE_ENTRIES];
    logic [7:0] green_reg [PALETTE_ENTRIES];
    logic [7:0] blue_reg  [PALETTE_ENTRIES];

    // table update: reset and ramp restore load all entries at once
    always_ff @(posedge aclk) begin
        if (!aresetn || wr.ramp) begin
            for (int i = 0; i < PALETTE_ENTRIES; i++) begin
                red_reg[i]   <= ramp_value(PEN_W'(i));
                green_reg[i] <= ramp_value(PEN_W'(i));
                blue_reg[i]  <= ramp_value(PEN_W'(i));
            end
        end else begin
            if (wr.we_r) red_reg[wr.pen]   <= wr.r;
            if (wr.we_g) green_reg[wr.pen] <= wr.g;
            if (wr.we_b) blue_reg[wr.pen]  <= wr.b;
        end
    end

    // read the value as it stands after this transfer's write
    always_comb begin
        if (wr.ramp) begin
            rd_r = ramp_value(rd_pen);
            rd_g = ramp_value(rd_pen);
            rd_b = ramp_value(rd_pen);
        end else begin
            rd_r = (wr.we_r && wr.pen == rd_pen) ? wr.r : red_reg[rd_pen];
            rd_g = (wr.we_g && wr.pen == rd_pen) ? wr.g : green_reg[rd_pen];
            rd_b = (wr.we_b && wr.pen == rd_pen) ? wr.b : blue_reg[rd_pen];
        end
    end

endmodule

### tb/sv/display_list_palette_engine_test.sv
// Testbench for the display list palette engine: list walking, line stepping and palette checks
`timescale 1ns / 1ps

module display_list_palette_engine_test;
    import dlpe_pkg::*;

    // mode value outside the named ones; the block must leave its state alone
    localparam logic [1:0] MODE_SPARE = 2'd3;
    // register index with nothing behind it
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 4'd9;

    // header word flag positions
    localparam int HDR_LOAD_PREV = 15;
    localparam int HDR_LOAD_CUR  = 16;
    localparam int HDR_PREV_OWN  = 17;
    localparam int HDR_RELATIVE  = 18;

    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 340;

    typedef struct packed {
        logic                         fetch_request;
        logic [LIST_ADDRESS_BITS-1:0] fetch_address;
        logic                         entry_done;
        logic [31:0]                  current_bitmap;
        logic [31:0]                  previous_bitmap;
        logic [23:0]                  background_colour;
        logic [31:0]                  display_control;
        logic [31:0]                  entry_header;
        logic [7:0]                   pen_red;
        logic [7:0]                   pen_green;
        logic [7:0]                   pen_blue;
    } line_state_t;

    // shadow of the engine state and the queue of line states it predicts
    class palette_scoreboard;
        logic [LIST_ADDRESS_BITS-1:0] head_address;
        logic                         swap_words;
        logic [2:0]                   word_step;
        logic [5:0]                   commands_owed;
        logic [31:0]                  header;
        logic [LIST_ADDRESS_BITS-1:0] list_ptr;
        logic [LIST_ADDRESS_BITS-1:0] next_ptr;
        logic [31:0]                  cur_bitmap;
        logic [31:0]                  prev_bitmap;
        logic [10:0]                  pitch;
        logic [8:0]                   lines_owed;
        logic                         stopped;
        logic                         chain_pending;
        logic                         ignore_ctl;
        logic [23:0]                  background;
        logic [31:0]                  control;
        logic [7:0]                   red [PALETTE_ENTRIES];
        logic [7:0]                   green [PALETTE_ENTRIES];
        logic [7:0]                   blue [PALETTE_ENTRIES];
        line_state_t                  line_states_q [$];
        int                           mismatches;
        int                           results_checked;

        function new();
            head_address    = HEAD_RESET;
            swap_words      = 1'b0;
            word_step       = PH_HDR;
            commands_owed   = '0;
            header          = '0;
            list_ptr        = '0;
            next_ptr        = '0;
            cur_bitmap      = '0;
            prev_bitmap     = '0;
            pitch           = 11'd320;
            lines_owed      = '0;
            stopped         = 1'b1;
            chain_pending   = 1'b0;
            ignore_ctl      = 1'b0;
            background      = '0;
            control         = '0;
            mismatches      = 0;
            results_checked = 0;
            restore_ramp();
        endfunction

        function void restore_ramp();
            for (int j = 0; j < PALETTE_ENTRIES; j++) begin
                red[j]   = 8'(j * 8 + j / 4);
                green[j] = 8'(j * 8 + j / 4);
                blue[j]  = 8'(j * 8 + j / 4);
            end
        endfunction

        // two-word step within a line, then a jump to the next line
        function logic [31:0] step_bitmap(logic [31:0] a);
            if (a[1])
                return a + {19'd0, pitch, 2'b00} - 32'd2;
            return a + 32'd2;
        endfunction

        // wrap up a non-zero entry; returns 1 when the next entry is to be fetched
        function logic close_entry();
            logic [8:0] lines;
            lines = header[8:0];
            word_step = PH_HDR;
            commands_owed = '0;
            case (header[25:23])
                3'd1:    pitch = 11'd384;
                3'd2:    pitch = 11'd512;
                3'd3:    pitch = 11'd640;
                3'd4:    pitch = 11'd1024;
                default: pitch = 11'd320;
            endcase
            list_ptr = next_ptr;
            lines_owed = lines;
            if (lines != 0) begin
                chain_pending = 1'b0;
                return 1'b0;
            end
            if (chain_pending) begin
                chain_pending = 1'b0;
                return 1'b1;
            end
            stopped = 1'b1;
            return 1'b0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
            if (idx == CFG_HEAD)
                head_address = data[LIST_ADDRESS_BITS-1:0];
            else if (idx == CFG_SWAP)
                swap_words = data[0];
        endfunction

        // work one accepted item and queue the line state it leads to
        function void note_item(logic [1:0] mode, logic [31:0] w, logic [PEN_W-1:0] pen);
            line_state_t      want;
            logic             req;
            logic             done;
            logic [PEN_W-1:0] slot;
            req  = 1'b0;
            done = 1'b0;
            case (mode)
                MODE_FRAME: begin
                    list_ptr      = head_address;
                    word_step     = PH_HDR;
                    commands_owed = '0;
                    ignore_ctl    = 1'b0;
                    lines_owed    = '0;
                    stopped       = 1'b0;
                    chain_pending = 1'b1;
                    req           = 1'b1;
                end
                MODE_WORD: if (!stopped) begin
                    case (word_step)
                        PH_HDR: begin
                            if (w == 32'd0) begin
                                lines_owed    = 9'd511;
                                chain_pending = 1'b0;
                                done          = 1'b1;
                            end else begin
                                header        = w;
                                commands_owed = w[14:9];
                                ignore_ctl    = 1'b0;
                                word_step     = PH_CUR;
                            end
                        end
                        PH_CUR: begin
                            if (swap_words ? header[HDR_LOAD_PREV] : header[HDR_LOAD_CUR]) begin
                                if (swap_words)
                                    prev_bitmap = w;
                                else
                                    cur_bitmap = w;
                            end
                            word_step = PH_PREV;
                        end
                        PH_PREV: begin
                            if (swap_words ? header[HDR_LOAD_CUR] : header[HDR_LOAD_PREV]) begin
                                if (swap_words)
                                    cur_bitmap = w;
                                else
                                    prev_bitmap = w;
                            end
                            word_step = PH_NEXT;
                        end
                        PH_NEXT: begin
                            if (header[HDR_RELATIVE])
                                next_ptr = list_ptr + w[LIST_ADDRESS_BITS-1:0]
                                           + LIST_ADDRESS_BITS'(16);
                            else
                                next_ptr = w[LIST_ADDRESS_BITS-1:0];
                            if (commands_owed == 0) begin
                                req  = close_entry();
                                done = 1'b1;
                            end else begin
                                word_step = PH_CMD;
                            end
                        end
                        default: begin
                            // command word
                            if (!w[31]) begin
                                slot = w[28:24];
                                case (w[30:29])
                                    SEL_ALL: begin
                                        red[slot]   = w[23:16];
                                        green[slot] = w[15:8];
                                        blue[slot]  = w[7:0];
                                    end
                                    SEL_RED:   red[slot] = w[23:16];
                                    SEL_GREEN: green[slot] = w[15:8];
                                    default:   blue[slot] = w[7:0];
                                endcase
                            end else if (w[31:24] == CMD_BACKGROUND) begin
                                if (!ignore_ctl)
                                    background = {w[7:0], w[15:8], w[23:16]};
                            end else if (w[31:29] == CMD_CONTROL) begin
                                if (!ignore_ctl) begin
                                    control    = w;
                                    ignore_ctl = w[1];
                                end
                            end else if (w == CMD_RAMP) begin
                                if (!ignore_ctl)
                                    restore_ramp();
                            end
                            commands_owed = commands_owed - 6'd1;
                            if (commands_owed == 0) begin
                                req  = close_entry();
                                done = 1'b1;
                            end
                        end
                    endcase
                end
                MODE_LINE: begin
                    cur_bitmap = step_bitmap(cur_bitmap);
                    if (header[HDR_PREV_OWN])
                        prev_bitmap = step_bitmap(prev_bitmap);
                    else
                        prev_bitmap = cur_bitmap;
                    if (!stopped && lines_owed != 0) begin
                        lines_owed = lines_owed - 9'd1;
                        req = (lines_owed == 0);
                    end
                    control[0] = 1'b0;
                end
                default: ;
            endcase
            want.fetch_request     = req;
            want.fetch_address     = list_ptr;
            want.entry_done        = done;
            want.current_bitmap    = cur_bitmap;
            want.previous_bitmap   = prev_bitmap;
            want.background_colour = background;
            want.display_control   = control;
            want.entry_header      = header;
            want.pen_red           = red[pen];
            want.pen_green         = green[pen];
            want.pen_blue          = blue[pen];
            line_states_q.push_back(want);
        endfunction

        // one line per mismatch
        task report(string what);
            $display("MISMATCH result %0d: %s", results_checked, what);
            mismatches++;
        endtask

        task compare(string field, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %h, expected %h", field, got, want));
        endtask

        task check_result(line_state_t got);
            line_state_t want;
            if (line_states_q.size() == 0) begin
                report("result transfer with no item waiting");
                return;
            end
            want = line_states_q.pop_front();
            compare("fetch_request", 32'(got.fetch_request), 32'(want.fetch_request));
            compare("fetch_address", 32'(got.fetch_address), 32'(want.fetch_address));
            compare("entry_done", 32'(got.entry_done), 32'(want.entry_done));
            compare("current_bitmap", got.current_bitmap, want.current_bitmap);
            compare("previous_bitmap", got.previous_bitmap, want.previous_bitmap);
            compare("background_colour", 32'(got.background_colour),
                    32'(want.background_colour));
            compare("display_control", got.display_control, want.display_control);
            compare("entry_header", got.entry_header, want.entry_header);
            compare("pen_red", 32'(got.pen_red), 32'(want.pen_red));
            compare("pen_green", 32'(got.pen_green), 32'(want.pen_green));
            compare("pen_blue", 32'(got.pen_blue), 32'(want.pen_blue));
            results_checked++;
        endtask
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [1:0]                    s_mode = MODE_FRAME;
    logic [31:0]                   s_list_word = '0;
    logic [PEN_W-1:0]              s_pen_index = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic                          m_fetch_request;
    logic [LIST_ADDRESS_BITS-1:0]  m_fetch_address;
    logic                          m_entry_done;
    logic [31:0]                   m_current_bitmap;
    logic [31:0]                   m_previous_bitmap;
    logic [23:0]                   m_background_colour;
    logic [31:0]                   m_display_control;
    logic [31:0]                   m_entry_header;
    logic [7:0]                    m_pen_red;
    logic [7:0]                    m_pen_green;
    logic [7:0]                    m_pen_blue;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_INDEX_W-1:0]        cfg_index = CFG_HEAD;
    logic [31:0]                   cfg_data = '0;

    int                            items_sent = 0;
    int                            send_idle_pct = 0;
    int                            stall_pct = 0;
    logic                          holding = 1'b0;
    int                            quiet_cycles = 0;

    palette_scoreboard sb = new;

    display_list_palette_engine DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_mode              (s_mode),
        .s_list_word         (s_list_word),
        .s_pen_index         (s_pen_index),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_fetch_request     (m_fetch_request),
        .m_fetch_address     (m_fetch_address),
        .m_entry_done        (m_entry_done),
        .m_current_bitmap    (m_current_bitmap),
        .m_previous_bitmap   (m_previous_bitmap),
        .m_background_colour (m_background_colour),
        .m_display_control   (m_display_control),
        .m_entry_header      (m_entry_header),
        .m_pen_red           (m_pen_red),
        .m_pen_green         (m_pen_green),
        .m_pen_blue          (m_pen_blue),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // result receiver with random stalls and the long hold-off
    always @(posedge aclk) begin
        m_ready <= !holding && ($urandom_range(99) >= stall_pct);
    end

    // observe every transfer on all three channels
    always @(posedge aclk) begin : observe
        line_state_t seen;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen.fetch_request     = m_fetch_request;
                seen.fetch_address     = m_fetch_address;
                seen.entry_done        = m_entry_done;
                seen.current_bitmap    = m_current_bitmap;
                seen.previous_bitmap   = m_previous_bitmap;
                seen.background_colour = m_background_colour;
                seen.display_control   = m_display_control;
                seen.entry_header      = m_entry_header;
                seen.pen_red           = m_pen_red;
                seen.pen_green         = m_pen_green;
                seen.pen_blue          = m_pen_blue;
                sb.check_result(seen);
            end
            if (s_valid && s_ready)
                sb.note_item(s_mode, s_list_word, s_pen_index);
            if (cfg_valid && cfg_ready)
                sb.set_register(cfg_index, cfg_data);
        end
    end

    // watchdog on cycles with no transfer at all
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one item, with random idle cycles ahead of it, and wait for its transfer
    task automatic send_item(input logic [1:0] mode, input logic [31:0] word,
                             input logic [PEN_W-1:0] pen);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_mode      <= mode;
        s_list_word <= word;
        s_pen_index <= pen;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // list word, now and then preceded by a line end, a spare mode or a frame restart
    task automatic send_word(input logic [31:0] w);
        int r;
        r = $urandom_range(99);
        if (r < 8)
            send_item(MODE_LINE, $urandom, PEN_W'($urandom));
        else if (r < 10)
            send_item(MODE_SPARE, $urandom, PEN_W'($urandom));
        else if (r == 10)
            send_item(MODE_FRAME, $urandom, PEN_W'($urandom));
        send_item(MODE_WORD, w, PEN_W'($urandom));
    endtask

    // register write with junk above the field
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value,
                             input int width);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= ($urandom << width) | value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // stop offering and wait for every queued line state to come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.line_states_q.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // mostly well-formed frames with random content, the rest noise
    task automatic run_random(input int count);
        int          stop_at;
        int          r;
        int          lines;
        logic [31:0] hdr;
        logic [31:0] w;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 15) begin
                repeat ($urandom_range(1, 6))
                    send_item(2'($urandom_range(3)), $urandom, PEN_W'($urandom));
            end else begin
                send_item(MODE_FRAME, $urandom, PEN_W'($urandom));
                repeat ($urandom_range(1, 5)) begin
                    if ($urandom_range(9) == 0) begin
                        // zero header
                        send_word(32'd0);
                    end else begin
                        hdr = $urandom;
                        r = $urandom_range(99);
                        if (r < 15)
                            hdr[8:0] = 9'd0;
                        else if (r < 20)
                            hdr[8:0] = 9'($urandom);
                        else
                            hdr[8:0] = 9'($urandom_range(1, 4));
                        hdr[14:9] = ($urandom_range(99) < 3) ? 6'd63 : 6'($urandom_range(0, 6));
                        send_word(hdr);
                        repeat (3) send_word($urandom);
                        for (int c = 0; c < hdr[14:9]; c++) begin
                            w = $urandom;
                            case ($urandom_range(9))
                                0, 1, 2, 3: w[31] = 1'b0;
                                4: w[31:24] = CMD_BACKGROUND;
                                5: begin
                                    w[31:29] = CMD_CONTROL;
                                    w[1] = ($urandom_range(3) == 0);
                                end
                                6: w = CMD_RAMP;
                                // words with bit 31 set that match no command
                                7: w[31:30] = 2'b10;
                                8: begin
                                    w[31:29] = 3'b111;
                                    w[28:24] = 5'($urandom_range(1, 31));
                                end
                                default: ;
                            endcase
                            send_word(w);
                        end
                        // run down some or all of the entry's lines, now and then one more
                        lines = int'(hdr[8:0]);
                        if (lines > 5)
                            lines = $urandom_range(5);
                        repeat (lines + $urandom_range(1))
                            send_item(MODE_LINE, $urandom, PEN_W'($urandom));
                    end
                end
            end
        end
    endtask

    initial begin : stimulus
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(CFG_HEAD, 32'h000F_FFFF, LIST_ADDRESS_BITS);
        write_reg(CFG_SWAP, 32'h0, 1);

        // before any frame start the list is stopped
        send_item(MODE_WORD, 32'hFFFF_FFFF, 5'd31);
        send_item(MODE_LINE, 32'h0, 5'd0);
        send_item(MODE_SPARE, 32'hFFFF_FFFF, 5'd31);
        send_item(MODE_FRAME, 32'h0, 5'd1);
        // first entry with no lines chains to the next one
        send_item(MODE_WORD, 32'h0020_0000, 5'd2);
        send_item(MODE_WORD, 32'h1234_5678, 5'd3);
        send_item(MODE_WORD, 32'h0000_0000, 5'd4);
        send_item(MODE_WORD, 32'hFFFF_FFFF, 5'd5);
        // every flag set, widest pitch, relative next pointer, six commands, two lines
        send_item(MODE_WORD, 32'h0227_8C02, 5'd31);
        send_item(MODE_WORD, 32'hFFFF_FFFE, 5'd0);
        send_item(MODE_WORD, 32'h0000_0000, 5'd7);
        send_item(MODE_WORD, 32'hFFFF_FFFF, 5'd8);
        send_item(MODE_WORD, 32'h1FFF_FFFF, 5'd31);
        send_item(MODE_WORD, 32'h6012_3456, 5'd0);
        send_item(MODE_LINE, 32'hFFFF_FFFF, 5'd0);
        send_item(MODE_WORD, 32'hE0A1_B2C3, 5'd9);
        // control word that sets the ignore flag, then skipped commands
        send_item(MODE_WORD, 32'hC000_0003, 5'd10);
        send_item(MODE_WORD, 32'hE0FF_FFFF, 5'd11);
        send_item(MODE_WORD, 32'hFFFF_FFFF, 5'd31);
        send_item(MODE_LINE, 32'h0, 5'd12);
        send_item(MODE_LINE, 32'h0, 5'd13);
        send_item(MODE_WORD, 32'h0000_0000, 5'd14);
        // frame start while an entry is half read
        send_item(MODE_WORD, 32'h0000_0201, 5'd15);
        send_item(MODE_FRAME, 32'hFFFF_FFFF, 5'd16);

        for (int ph = 0; ph < 5; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_reg(CFG_HEAD, 32'h0, LIST_ADDRESS_BITS);
                    write_reg(CFG_SWAP, 32'h1, 1);
                    send_idle_pct = 0;
                    stall_pct <= 0;
                end
                1: begin
                    write_reg(CFG_HEAD, $urandom_range(20'hFFFFF), LIST_ADDRESS_BITS);
                    write_reg(CFG_SWAP, 32'h0, 1);
                    send_idle_pct = 79;
                    stall_pct <= 0;
                end
                2: begin
                    write_reg(CFG_HEAD, 32'h000F_FFFF, LIST_ADDRESS_BITS);
                    write_reg(CFG_SWAP, 32'h1, 1);
                    send_idle_pct = 0;
                    stall_pct <= 79;
                end
                3: begin
                    write_reg(CFG_HEAD, $urandom_range(20'hFFFFF), LIST_ADDRESS_BITS);
                    write_reg(CFG_SWAP, 32'h1, 1);
                    write_reg(CFG_SPARE, $urandom, 0);
                    send_idle_pct = 8;
                    stall_pct <= 8;
                end
                default: begin
                    write_reg(CFG_HEAD, 32'(HEAD_RESET), LIST_ADDRESS_BITS);
                    write_reg(CFG_SWAP, 32'h0, 1);
                    send_idle_pct = 0;
                    stall_pct <= 0;
                    // long receiver hold-off while the sender keeps offering
                    fork
                        begin
                            holding <= 1'b1;
                            repeat (HOLD_CYCLES) @(posedge aclk);
                            holding <= 1'b0;
                        end
                    join_none
                end
            endcase
            run_random(PHASE_ITEMS);
        end

        drain();
        repeat (4) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
